### rtl/core/kls_pkg.sv
// Shared types and codes for the keyframe linear sampler.
// No dependencies; the front, back, top level and testbench refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package kls_pkg;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] CASE_INTERP = 2'd0;
    localparam logic [1:0] CASE_FIRST  = 2'd1;
    localparam logic [1:0] CASE_LAST   = 2'd2;
    localparam logic [1:0] CASE_EMPTY  = 2'd3;

    // One classified item as it sits in the queue between front and back
    typedef struct packed {
        logic               is_query;
        logic [5:0]         key_index;
        logic [31:0]        key_time;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
        logic [31:0]        query_time;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

### rtl/core/kls_if.sv
// Channel interfaces of the keyframe linear sampler: request, result, config.
// Stand-alone; used by the top level and the back end.
`timescale 1ns / 1ps
`default_nettype none

interface kls_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [5:0]         key_index;
    logic [31:0]        key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic [31:0]        query_time;

    modport source (output valid, req_type, key_index, key_time, key_x, key_y, key_z,
                    query_time, input ready);
    modport sink   (input valid, req_type, key_index, key_time, key_x, key_y, key_z,
                    query_time, output ready);
endinterface

interface kls_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic [1:0]         sample_case;

    modport source (output valid, value_x, value_y, value_z, sample_case, input ready);
    modport sink   (input valid, value_x, value_y, value_z, sample_case, output ready);
endinterface

interface kls_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] key_count;

    modport source (output valid, key_count, input ready);
    modport sink   (input valid, key_count, output ready);
endinterface

`default_nettype wire

### rtl/core/kls_front.sv
// Front end: accepts request beats, drops writes to slots past the table,
// and holds the rest in a two-entry queue. Depends on kls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kls_front #(
    parameter int MAX_KEYS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire kls_pkg::t_item i_item,
    output logic               o_q_valid,
    input  wire logic          i_q_ready,
    output kls_pkg::t_item     o_q_item
);

    kls_pkg::t_item r_buf [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           accept;
    logic           keep;
    logic           pop;
    logic [10:0]    idx_ext;

    // Classify: a write beyond the table is taken and dropped
    assign idx_ext = {5'd0, i_item.key_index};
    assign o_ready = (r_cnt != 2'd2);
    assign accept  = i_valid && o_ready;
    assign keep    = accept && (i_item.is_query ||
                                (idx_ext < 11'(MAX_KEYS)));
    assign pop     = o_q_valid && i_q_ready;

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_buf[r_rp];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_buf[r_wp] <= i_item;
        end
    end

    // Queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (keep) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({keep, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/kls_back.sv
// Back end: key table, segment scan, fraction divider, shared multiplier,
// and the result register. Depends on kls_pkg and kls_if.
`timescale 1ns / 1ps
`default_nettype none

module kls_back #(
    parameter int MAX_KEYS = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    output logic                o_q_ready,
    input  wire kls_pkg::t_item i_q_item,
    input  wire logic           i_cfg_we,
    input  wire logic [6:0]     i_cfg_count,
    kls_res_if.source           o_res
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = AW + 1;
    localparam int KW = (CW > 7) ? CW : 7;

    kls_pkg::t_state r_state;
    kls_pkg::t_state n_state;

    logic [127:0]       r_mem [MAX_KEYS];
    logic [127:0]       r_rd;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [KW-1:0]      idx_ext;

    logic [6:0]         r_key_count;
    logic [KW-1:0]      cnt_n;
    logic [KW-1:0]      r_n;
    logic [31:0]        r_qt;
    logic [AW-1:0]      r_idx;
    logic [31:0]        r_prev_t;
    logic signed [31:0] r_v0 [3];
    logic signed [31:0] r_v1 [3];
    logic [31:0]        r_rem;
    logic [31:0]        r_den;
    logic [15:0]        r_frac;
    logic [4:0]         r_step;
    logic signed [49:0] r_prod;
    logic signed [31:0] r_res [3];
    logic [1:0]         r_res_case;
    logic               r_ov;

    logic [31:0]        rd_t;
    logic signed [31:0] rd_v [3];
    logic               first_hold;
    logic               hit;
    logic               more;
    logic [32:0]        rem2;
    logic               out_free;
    logic signed [32:0] diff;
    logic signed [31:0] v0_sel;
    logic signed [31:0] v1_sel;

    assign rd_t    = r_rd[127:96];
    assign rd_v[0] = r_rd[95:64];
    assign rd_v[1] = r_rd[63:32];
    assign rd_v[2] = r_rd[31:0];

    // Effective key count, clipped to the table depth
    assign cnt_n = (KW'(r_key_count) > KW'(MAX_KEYS)) ? KW'(MAX_KEYS) : KW'(r_key_count);
    assign idx_ext = KW'(i_q_item.key_index);

    assign first_hold = (r_n == KW'(1)) || (r_qt <= rd_t);
    assign hit  = (r_prev_t <= r_qt) && (r_qt <= rd_t);
    assign more = (KW'(r_idx) + KW'(1)) < r_n;
    assign rem2 = {r_rem, 1'b0};
    assign out_free = !r_ov || o_res.ready;

    // Component picked for the shared multiplier
    always_comb begin
        case (r_step[1:0])
            2'd0:    begin v0_sel = r_v0[0]; v1_sel = r_v1[0]; end
            2'd1:    begin v0_sel = r_v0[1]; v1_sel = r_v1[1]; end
            default: begin v0_sel = r_v0[2]; v1_sel = r_v1[2]; end
        endcase
    end
    assign diff = 33'(v1_sel) - 33'(v0_sel);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kls_pkg::ST_IDLE: begin
                if (i_q_valid && i_q_item.is_query) begin
                    n_state = (cnt_n == KW'(0)) ? kls_pkg::ST_EMIT : kls_pkg::ST_FIRST;
                end
            end
            kls_pkg::ST_FIRST: begin
                n_state = first_hold ? kls_pkg::ST_EMIT : kls_pkg::ST_SCAN;
            end
            kls_pkg::ST_SCAN: begin
                if (hit) begin
                    n_state = ((r_prev_t == rd_t) || (r_qt == rd_t)) ?
                              kls_pkg::ST_EMIT : kls_pkg::ST_DIV;
                end else if (!more) begin
                    n_state = kls_pkg::ST_EMIT;
                end
            end
            kls_pkg::ST_DIV: begin
                if (r_step == 5'd15) begin
                    n_state = kls_pkg::ST_MUL;
                end
            end
            kls_pkg::ST_MUL:  n_state = kls_pkg::ST_ADD;
            kls_pkg::ST_ADD: begin
                n_state = (r_step == 5'd2) ? kls_pkg::ST_EMIT : kls_pkg::ST_MUL;
            end
            kls_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = kls_pkg::ST_IDLE;
                end
            end
            default: n_state = kls_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: queue pop, table write, table read
    always_comb begin
        o_q_ready = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        case (r_state)
            kls_pkg::ST_IDLE: begin
                o_q_ready = 1'b1;
                wr_en     = i_q_valid && !i_q_item.is_query;
                rd_en     = i_q_valid && i_q_item.is_query;
            end
            kls_pkg::ST_FIRST: begin
                rd_en   = 1'b1;
                rd_addr = AW'(1);
            end
            kls_pkg::ST_SCAN: begin
                rd_en   = 1'b1;
                rd_addr = r_idx + AW'(1);
            end
            default: ;
        endcase
    end

    // Key table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[idx_ext[AW-1:0]] <= {i_q_item.key_time, i_q_item.key_x,
                                       i_q_item.key_y, i_q_item.key_z};
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // State and config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kls_pkg::ST_IDLE;
            r_key_count <= 7'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_key_count <= i_cfg_count;
            end
        end
    end

    // Datapath: scan, divide, multiply and accumulate the result
    always_ff @(posedge i_clk) begin
        case (r_state)
            kls_pkg::ST_IDLE: begin
                r_qt       <= i_q_item.query_time;
                r_n        <= cnt_n;
                r_res[0]   <= '0;
                r_res[1]   <= '0;
                r_res[2]   <= '0;
                r_res_case <= kls_pkg::CASE_EMPTY;
            end
            kls_pkg::ST_FIRST: begin
                r_res[0]   <= rd_v[0];
                r_res[1]   <= rd_v[1];
                r_res[2]   <= rd_v[2];
                r_res_case <= kls_pkg::CASE_FIRST;
                r_prev_t   <= rd_t;
                r_v0[0]    <= rd_v[0];
                r_v0[1]    <= rd_v[1];
                r_v0[2]    <= rd_v[2];
                r_idx      <= AW'(1);
            end
            kls_pkg::ST_SCAN: begin
                r_v1[0] <= rd_v[0];
                r_v1[1] <= rd_v[1];
                r_v1[2] <= rd_v[2];
                r_rem   <= r_qt - r_prev_t;
                r_den   <= rd_t - r_prev_t;
                r_step  <= 5'd0;
                if (hit) begin
                    r_res_case <= kls_pkg::CASE_INTERP;
                    if (r_prev_t == rd_t) begin
                        r_res[0] <= r_v0[0];
                        r_res[1] <= r_v0[1];
                        r_res[2] <= r_v0[2];
                    end else begin
                        r_res[0] <= rd_v[0];
                        r_res[1] <= rd_v[1];
                        r_res[2] <= rd_v[2];
                    end
                end else begin
                    // Advance one segment, or hold the last key
                    r_res[0]   <= rd_v[0];
                    r_res[1]   <= rd_v[1];
                    r_res[2]   <= rd_v[2];
                    r_res_case <= kls_pkg::CASE_LAST;
                    r_prev_t   <= rd_t;
                    r_v0[0]    <= rd_v[0];
                    r_v0[1]    <= rd_v[1];
                    r_v0[2]    <= rd_v[2];
                    r_idx      <= r_idx + AW'(1);
                end
            end
            kls_pkg::ST_DIV: begin
                // One restoring quotient bit per cycle
                if (rem2 >= {1'b0, r_den}) begin
                    r_rem  <= 32'(rem2 - {1'b0, r_den});
                    r_frac <= {r_frac[14:0], 1'b1};
                end else begin
                    r_rem  <= rem2[31:0];
                    r_frac <= {r_frac[14:0], 1'b0};
                end
                r_step <= (r_step == 5'd15) ? 5'd0 : r_step + 5'd1;
            end
            kls_pkg::ST_MUL: begin
                r_prod <= diff * $signed({1'b0, r_frac});
            end
            kls_pkg::ST_ADD: begin
                case (r_step[1:0])
                    2'd0:    r_res[0] <= v0_sel + r_prod[47:16];
                    2'd1:    r_res[1] <= v0_sel + r_prod[47:16];
                    default: r_res[2] <= v0_sel + r_prod[47:16];
                endcase
                r_res_case <= kls_pkg::CASE_INTERP;
                r_step     <= r_step + 5'd1;
            end
            default: ;
        endcase
    end

    // Result register: load from the emit state, drop on handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == kls_pkg::ST_EMIT && out_free) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == kls_pkg::ST_EMIT && out_free) begin
            o_res.value_x     <= r_res[0];
            o_res.value_y     <= r_res[1];
            o_res.value_z     <= r_res[2];
            o_res.sample_case <= r_res_case;
        end
    end

    assign o_res.valid = r_ov;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == kls_pkg::ST_DIV |-> r_den != 32'd0)
        else $error("divider running on a zero-length segment");

    a_scan_in_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == kls_pkg::ST_SCAN |-> KW'(r_idx) < r_n)
        else $error("segment scan past the last key");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.sample_case == kls_pkg::CASE_EMPTY |->
        o_res.value_x == 32'sd0 && o_res.value_y == 32'sd0 && o_res.value_z == 32'sd0)
        else $error("empty track gave a nonzero value");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_state == kls_pkg::ST_IDLE)
        else $error("table write started a query");

endmodule

`default_nettype wire

### rtl/core/keyframe_linear_sampler.sv
// Top level of the keyframe linear sampler: front queue plus back end.
// Depends on kls_pkg, kls_if, kls_front and kls_back.
//
//   channel   dir   carries                                   handshake
//   i_req     in    req_type, key_index, key_time, xyz, qtime valid/ready
//   o_res     out   value_x/y/z, sample_case                  valid/ready
//   i_cfg     in    key_count                                 valid/ready
//
// A key write leaves the queue and the back end stays idle. A query on an
// empty track goes straight to emit; else key 0 is read and, if it does not
// hold, one segment is scanned per read (single read port of the key table);
// interpolation then runs the bit-serial divider and the shared multiplier
// per component. The result is valid from the edge that ends the query.
// Reset (synchronous, active low) clears key_count, the queue and the FSM.
// The two-entry queue lets requests arrive while the back end is busy;
// a stalled result holds in the output register and stalls the back end.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_linear_sampler #(
    parameter int MAX_KEYS = 64
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    kls_req_if.sink    i_req,
    kls_cfg_if.sink    i_cfg,
    kls_res_if.source  o_res
);

    kls_pkg::t_item req_item;
    kls_pkg::t_item q_item;
    logic           q_valid;
    logic           q_ready;

    // Pack the request beat
    always_comb begin
        req_item.is_query   = (i_req.req_type == kls_pkg::REQ_QUERY);
        req_item.key_index  = i_req.key_index;
        req_item.key_time   = i_req.key_time;
        req_item.key_x      = i_req.key_x;
        req_item.key_y      = i_req.key_y;
        req_item.key_z      = i_req.key_z;
        req_item.query_time = i_req.query_time;
    end

    assign i_cfg.ready = 1'b1;

    kls_front #(
        .MAX_KEYS (MAX_KEYS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_req.valid),
        .o_ready   (i_req.ready),
        .i_item    (req_item),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_item  (q_item)
    );

    kls_back #(
        .MAX_KEYS (MAX_KEYS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_item    (q_item),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_count (i_cfg.key_count),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

### verif/tb_top.sv
// Testbench for keyframe_linear_sampler: directed and random key writes and queries.
// Depends on kls_pkg and kls_if; checks each result beat against an in-bench predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int N_KEYS    = 64;
    localparam int IDLE_LIM  = 20000;
    localparam int DRAIN_CYC = 120;
    localparam int EXP_DEPTH = 1024;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         scase;
    } t_sample;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    kls_req_if req_ch ();
    kls_res_if res_ch ();
    kls_cfg_if cfg_ch ();

    keyframe_linear_sampler #(.MAX_KEYS(N_KEYS)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .i_cfg  (cfg_ch),
        .o_res  (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the key table and count
    logic [31:0]        tbl_t [N_KEYS];
    logic signed [31:0] tbl_x [N_KEYS];
    logic signed [31:0] tbl_y [N_KEYS];
    logic signed [31:0] tbl_z [N_KEYS];
    bit                 tbl_wr [N_KEYS];
    logic [6:0]         count_shadow;

    // Expected results in query order, kept in a ring
    t_sample exp_buf [EXP_DEPTH];
    int  exp_wr = 0;
    int  exp_rd = 0;
    int  fail_cnt = 0;
    int  idle_cycles = 0;

    function automatic logic signed [31:0] lerp(logic signed [31:0] a,
                                                logic signed [31:0] b, logic [15:0] f);
        longint d;
        longint p;
        longint q;
        d = longint'(b) - longint'(a);
        p = d * longint'({48'd0, f});
        q = p >>> 16;
        return 32'(longint'(a) + q);
    endfunction

    function automatic t_sample sample_track(logic [31:0] qt);
        t_sample    r;
        int         n;
        logic [31:0] t0;
        logic [31:0] t1;
        logic [63:0] num;
        logic [15:0] f;
        n = (count_shadow > N_KEYS) ? N_KEYS : count_shadow;
        if (n == 0) begin
            r = '{0, 0, 0, kls_pkg::CASE_EMPTY};
            return r;
        end
        if (n == 1 || qt <= tbl_t[0]) begin
            r = '{tbl_x[0], tbl_y[0], tbl_z[0], kls_pkg::CASE_FIRST};
            return r;
        end
        for (int i = 0; i + 1 < n; i++) begin
            t0 = tbl_t[i];
            t1 = tbl_t[i+1];
            if (t0 <= qt && qt <= t1) begin
                if (t0 == t1) begin
                    r = '{tbl_x[i], tbl_y[i], tbl_z[i], kls_pkg::CASE_INTERP};
                end else if (qt == t1) begin
                    r = '{tbl_x[i+1], tbl_y[i+1], tbl_z[i+1], kls_pkg::CASE_INTERP};
                end else begin
                    num = {32'd0, qt - t0} << 16;
                    f = 16'(num / {32'd0, t1 - t0});
                    r.x = lerp(tbl_x[i], tbl_x[i+1], f);
                    r.y = lerp(tbl_y[i], tbl_y[i+1], f);
                    r.z = lerp(tbl_z[i], tbl_z[i+1], f);
                    r.scase = kls_pkg::CASE_INTERP;
                end
                return r;
            end
        end
        r = '{tbl_x[n-1], tbl_y[n-1], tbl_z[n-1], kls_pkg::CASE_LAST};
        return r;
    endfunction

    // Drive one request beat after a random gap, then update the shadow table or queue the expected result.
    // Valid stays high after the beat so a zero gap gives back-to-back beats.
    task automatic send_req(logic rt, logic [5:0] idx, logic [31:0] kt,
                            logic [31:0] kx, logic [31:0] ky, logic [31:0] kz,
                            logic [31:0] qt);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rt;
        req_ch.key_index  <= idx;
        req_ch.key_time   <= kt;
        req_ch.key_x      <= kx;
        req_ch.key_y      <= ky;
        req_ch.key_z      <= kz;
        req_ch.query_time <= qt;
        do @(posedge i_clk); while (!req_ch.ready);
        if (rt == kls_pkg::REQ_WRITE) begin
            tbl_t[idx] = kt;
            tbl_x[idx] = kx;
            tbl_y[idx] = ky;
            tbl_z[idx] = kz;
            tbl_wr[idx] = 1'b1;
        end else begin
            exp_buf[exp_wr % EXP_DEPTH] = sample_track(qt);
            exp_wr++;
        end
    endtask

    // Drop request valid and step past the current edge
    task automatic req_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_key(int idx, logic [31:0] kt, logic [31:0] kx,
                             logic [31:0] ky, logic [31:0] kz);
        send_req(kls_pkg::REQ_WRITE, 6'(idx), kt, kx, ky, kz, $urandom);
    endtask

    task automatic query(logic [31:0] qt);
        send_req(kls_pkg::REQ_QUERY, 6'($urandom), $urandom, $urandom, $urandom,
                 $urandom, qt);
    endtask

    // Wait for all results, then let writes still in flight settle
    task automatic drain();
        req_idle();
        wait (exp_wr == exp_rd);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic set_count(logic [6:0] cnt);
        drain();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.key_count <= cnt;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        count_shadow = cnt;
    endtask

    // Query only times whose segment search touches written slots
    function automatic bit safe_count(int n);
        for (int i = 0; i < n && i < N_KEYS; i++)
            if (!tbl_wr[i]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic test_empty_track();
        query(32'd0);
        query(32'hFFFF_FFFF);
    endtask

    task automatic test_directed_cases();
        write_key(0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        write_key(1, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        write_key(2, 32'h0003_0000, 32'h1234_5678, 32'd5, 32'hFFFF_0000);
        write_key(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h0001_0000);
        write_key(63, 32'h0000_0001, 32'd1, 32'd2, 32'd3);
        set_count(7'd1);
        query(32'h0005_0000);
        set_count(7'd4);
        query(32'd0);               // before first key
        query(32'h0001_0000);       // equal to first key
        query(32'h0002_0000);       // midpoint, extreme values
        query(32'h0001_0001);
        query(32'h0002_FFFF);
        query(32'h0003_0000);       // end of the first segment
        query(32'h8000_0000);
        query(32'hFFFF_FFFF);       // last key exactly
        set_count(7'd3);
        query(32'hFFFF_FFFF);       // beyond last key
    endtask

    task automatic test_full_and_oversized();
        logic [31:0] t;
        t = 32'd0;
        for (int i = 0; i < N_KEYS; i++) begin
            t = t + $urandom_range(0, 32'h0004_0000);
            write_key(i, t, $urandom, $urandom, $urandom);
        end
        set_count(7'd64);
        query(t);
        query(t + 32'd1);
        set_count(7'd127);          // clamps to the table size
        query(t + 32'd1);
        query($urandom_range(0, t));
        set_count(7'd100);
        query($urandom_range(0, t));
    endtask

    task automatic test_random_tracks();
        int n;
        int k;
        logic [31:0] t;
        logic [31:0] tmax;
        for (int phase = 0; phase < 14; phase++) begin
            case ($urandom_range(0, 3))
                0: n = $urandom_range(1, 4);
                1: n = $urandom_range(2, 16);
                default: n = $urandom_range(2, 64);
            endcase
            t = $urandom_range(0, 32'h0010_0000);
            // Mostly ascending tracks, sometimes unordered or flat runs
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 9))
                    0: t = $urandom;
                    1: t = t;
                    default: t = t + $urandom_range(1, 32'h0008_0000);
                endcase
                write_key(i, t, $urandom, $urandom, $urandom);
            end
            tmax = t;
            if ($urandom_range(0, 1)) write_key($urandom_range(n, 63), $urandom,
                                                $urandom, $urandom, $urandom);
            if (phase == 6) begin
                set_count(7'd0);
                query($urandom);
            end
            set_count(7'(n));
            if (!safe_count(n)) continue;
            for (int j = 0; j < 36; j++) begin
                k = $urandom_range(0, 9);
                if (k == 0) query($urandom);
                else if (k == 1) query(tbl_t[$urandom_range(0, n - 1)]);
                else if (k == 2 && n < N_KEYS && tbl_wr[n] == 0)
                    query($urandom_range(0, tmax));
                else if (k == 3 && safe_count(N_KEYS - 1) == 0) begin
                    // rewrite an in-range slot in place
                    write_key($urandom_range(0, n - 1), tbl_t[$urandom_range(0, n - 1)],
                              $urandom, $urandom, $urandom);
                end else query($urandom_range(0, tmax + 32'h0002_0000));
                if (j == 20) begin
                    req_idle();
                    wait (exp_wr == exp_rd);
                end
            end
        end
    endtask

    // Result side: random stalls and check against oldest expectation
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            int stall;
            t_sample e;
            @(posedge i_clk);
            if (!(res_ch.valid && res_ch.ready)) begin
                if (!res_ch.ready) begin
                    stall = $urandom_range(0, 13);
                    if ($urandom_range(0, 3) == 0) stall = 0;
                    repeat (stall) @(posedge i_clk);
                    res_ch.ready <= 1'b1;
                end
                continue;
            end
            if (exp_wr == exp_rd) begin
                $display("%0t: result beat with no query waiting: x=%h y=%h z=%h case=%0d",
                         $time, res_ch.value_x, res_ch.value_y, res_ch.value_z,
                         res_ch.sample_case);
                fail_cnt++;
            end else begin
                e = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (res_ch.value_x !== e.x || res_ch.value_y !== e.y ||
                    res_ch.value_z !== e.z || res_ch.sample_case !== e.scase) begin
                    $display("%0t: mismatch expected x=%h y=%h z=%h case=%0d",
                             $time, e.x, e.y, e.z, e.scase);
                    $display("%0t:          actual   x=%h y=%h z=%h case=%0d",
                             $time, res_ch.value_x, res_ch.value_y, res_ch.value_z,
                             res_ch.sample_case);
                    fail_cnt++;
                end
            end
            res_ch.ready <= 1'b0;
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = kls_pkg::REQ_WRITE;
        req_ch.key_index = '0;
        req_ch.key_time = '0;
        req_ch.key_x = '0;
        req_ch.key_y = '0;
        req_ch.key_z = '0;
        req_ch.query_time = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.key_count = '0;
        count_shadow = '0;
        for (int i = 0; i < N_KEYS; i++) tbl_wr[i] = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_track();
        test_directed_cases();
        test_full_and_oversized();
        test_random_tracks();
        drain();
        if (fail_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/kls_pkg.sv
rtl/core/kls_if.sv
rtl/core/kls_front.sv
rtl/core/kls_back.sv
rtl/core/keyframe_linear_sampler.sv
verif/tb_top.sv
